// File: src/bhq_pkg.sv
// Package for the binary min-heap priority queue.
// Holds the item types, operation and status codes, and the cell link types.
// Used by bhq_cell, bhq_chain and binary_min_heap_queue_top; depends on nothing.
package bhq_pkg;

	localparam int DEPTH = 1024;
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam logic [1:0] OP_INSERT  = 2'd0;
	localparam logic [1:0] OP_PEEK    = 2'd1;
	localparam logic [1:0] OP_EXTRACT = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam logic signed [31:0] EMPTY_DATA = -32'sd1;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] data;
		logic [1:0]         status;
		logic [CNT_W-1:0]   count;
	} res_t;

	// Broadcast to every cell in the row.
	typedef struct packed {
		logic               ins;
		logic               ext;
		logic signed [31:0] value;
	} ctl_t;

	// What a cell shows its neighbors.
	typedef struct packed {
		logic               occ;
		logic               move;
		logic signed [31:0] val;
	} link_t;

endpackage

// File: src/bhq_cell.sv
// One cell of the sorted row: holds one entry and its occupied flag.
// On insert it keeps, takes the new value, or takes its left neighbor; on extract
// it takes its right neighbor. Depends on bhq_pkg.
module bhq_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  bhq_pkg::ctl_t ctl,
	input  bhq_pkg::link_t prev,
	input  bhq_pkg::link_t next,
	output bhq_pkg::link_t own
);

	logic               occ_q;
	logic signed [31:0] val_q;
	logic               move;

	// The new value belongs at or before this cell.
	assign move = !occ_q || ($signed(ctl.value) < $signed(val_q));

	assign own.occ  = occ_q;
	assign own.move = move;
	assign own.val  = val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctl.ins && move) begin
			occ_q <= prev.move ? prev.occ : 1'b1;
		end else if (ctl.ext) begin
			occ_q <= next.occ;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ins && move) begin
			val_q <= prev.move ? prev.val : ctl.value;
		end else if (ctl.ext) begin
			val_q <= next.val;
		end
	end

endmodule

// File: src/bhq_chain.sv
// Row of bhq_cell instances kept in ascending order, smallest at the head.
// Wires each cell to its neighbors and presents the head cell.
// Depends on bhq_pkg and bhq_cell.
module bhq_chain (
	input  logic           clk,
	input  logic           arst_n,
	input  bhq_pkg::ctl_t  ctl,
	output bhq_pkg::link_t head
);

	localparam bhq_pkg::link_t LEFT_END  = '{occ: 1'b1, move: 1'b0, val: 32'sd0};
	localparam bhq_pkg::link_t RIGHT_END = '{occ: 1'b0, move: 1'b0, val: 32'sd0};

	bhq_pkg::link_t links [bhq_pkg::DEPTH];

	for (genvar i = 0; i < bhq_pkg::DEPTH; i++) begin : g_cell
		bhq_pkg::link_t prev_l;
		bhq_pkg::link_t next_l;

		if (i == 0) begin : g_first
			assign prev_l = LEFT_END;
		end else begin : g_mid_l
			assign prev_l = links[i-1];
		end

		if (i == bhq_pkg::DEPTH - 1) begin : g_last
			assign next_l = RIGHT_END;
		end else begin : g_mid_r
			assign next_l = links[i+1];
		end

		bhq_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.prev   (prev_l),
			.next   (next_l),
			.own    (links[i])
		);
	end

	assign head = links[0];

endmodule

// File: src/binary_min_heap_queue_top.sv
// Minimum priority queue of signed 32-bit values, up to 1024 entries, with
// item handshake on both sides. Depends on bhq_pkg and bhq_chain.
//
// Command items are insert, peek minimum and extract minimum. The entries sit
// in ascending order in a row of 1024 cells that all update together, so an
// insert or an extract completes in the cycle it is accepted. The result item
// appears in the output register on the next cycle, and a new command is taken
// in every cycle unless that register is full and stalled. Peek and extract on
// an empty queue return -1 with status empty; an insert into a full queue is
// dropped with status full. Every result carries the entry count after the
// operation.
module binary_min_heap_queue_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  bhq_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_stall,
	output bhq_pkg::res_t res
);

	localparam logic [bhq_pkg::CNT_W-1:0] FULL_CNT = bhq_pkg::CNT_W'(bhq_pkg::DEPTH);

	logic                        res_valid_q;
	bhq_pkg::res_t               res_q;
	logic [bhq_pkg::CNT_W-1:0]   cnt_q;
	logic [bhq_pkg::CNT_W-1:0]   cnt_nxt;
	logic                        acc;
	logic                        full;
	logic                        empty;
	bhq_pkg::ctl_t               ctl;
	bhq_pkg::link_t              head;
	bhq_pkg::res_t               res_nxt;

	assign cmd_stall = res_valid_q && res_stall;
	assign acc       = cmd_valid && !cmd_stall;
	assign full      = (cnt_q == FULL_CNT);
	assign empty     = (cnt_q == '0);

	assign ctl.ins   = acc && (cmd.op == bhq_pkg::OP_INSERT) && !full;
	assign ctl.ext   = acc && (cmd.op == bhq_pkg::OP_EXTRACT) && !empty;
	assign ctl.value = cmd.value;

	bhq_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.head   (head)
	);

	always_comb begin
		cnt_nxt = cnt_q;
		if (ctl.ins) begin
			cnt_nxt = cnt_q + 1'b1;
		end else if (ctl.ext) begin
			cnt_nxt = cnt_q - 1'b1;
		end

		res_nxt.data   = 32'sd0;
		res_nxt.status = bhq_pkg::ST_OK;
		res_nxt.count  = cnt_nxt;
		unique case (cmd.op) inside
			bhq_pkg::OP_INSERT: begin
				if (full) begin
					res_nxt.status = bhq_pkg::ST_FULL;
				end
			end
			bhq_pkg::OP_PEEK, bhq_pkg::OP_EXTRACT: begin
				if (empty) begin
					res_nxt.data   = bhq_pkg::EMPTY_DATA;
					res_nxt.status = bhq_pkg::ST_EMPTY;
				end else begin
					res_nxt.data = head.val;
				end
			end
			default: begin
				res_nxt.status = bhq_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_nxt;
			if (acc) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_q <= res_nxt;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL_CNT)
		else $error("entry count above capacity");

	a_head_occ: assert property (@(posedge clk) disable iff (!arst_n)
		head.occ == !empty)
		else $error("head cell occupancy disagrees with entry count");

	a_ins_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ins |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("insert did not advance entry count");

	a_acc_res: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> res_valid_q)
		else $error("accepted item produced no result");

endmodule
